// File: rtl/core/tbwpc_pkg.sv
// Shared types, constants and the y coordinate function of the waveform peak column block.
package tbwpc_pkg;

    // Six band magnitudes in the order low, mid, high with left before right.
    localparam int NUM_MAGS = 6;
    localparam int NUM_BANDS = 3;

    // floor(x / 510) is taken as (x * RECIP_510) >> RECIP_SHIFT, exact for x below 2^21.
    localparam int RECIP_SHIFT = 30;
    localparam logic [21:0] RECIP_510 = 22'd2105377;
    localparam int SCALE_W = 34;

    localparam logic [4:0] FPC_RESET = 5'd1;
    localparam logic [11:0] HEIGHT_RESET = 12'd256;
    localparam logic [12:0] COLS_RESET = 13'd1024;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 34'd538976512;

    localparam logic [8:0] MAG_MID = 9'd255;

    typedef enum logic [1:0] {
        REG_FRAMES_PER_COLUMN = 2'd0,
        REG_DISPLAY_HEIGHT = 2'd1,
        REG_COLUMN_COUNT = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [7:0] low_left;
        logic [7:0] low_right;
        logic [7:0] mid_left;
        logic [7:0] mid_right;
        logic [7:0] high_left;
        logic [7:0] high_right;
        logic in_range;
    } in_item_t;

    typedef struct packed {
        logic [11:0] column_index;
        logic [11:0] low_top;
        logic [11:0] low_bottom;
        logic [11:0] mid_top;
        logic [11:0] mid_bottom;
        logic [11:0] high_top;
        logic [11:0] high_bottom;
        logic last_column;
    } out_item_t;

    typedef struct packed {
        logic [4:0] frames_per_column;
        logic [12:0] column_count;
        logic [SCALE_W-1:0] height_scale;
    } cfg_t;

    // One finished column on its way to the scaler.
    typedef struct packed {
        logic [11:0] column_index;
        logic [NUM_MAGS-1:0][7:0] peaks;
        logic column_valid;
        logic last_column;
    } col_t;

    // floor(display_height * span / 510), with height_scale = display_height * RECIP_510.
    function automatic logic [11:0] y_coord(input logic [8:0] span,
                                            input logic [SCALE_W-1:0] height_scale);
        logic [SCALE_W+8:0] prod;
        prod = (SCALE_W + 9)'(span) * (SCALE_W + 9)'(height_scale);
        return prod[RECIP_SHIFT+11:RECIP_SHIFT];
    endfunction

endpackage

// File: rtl/core/tbwpc_regs.sv
// Configuration registers behind the APB-style port, with the precomputed height scale.
module tbwpc_regs (
    input  logic aclk,
    input  logic aresetn,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [3:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready,
    output tbwpc_pkg::cfg_t cfg
);

    logic [4:0] fpc_reg;
    logic [11:0] height_reg;
    logic [12:0] cols_reg;
    logic [tbwpc_pkg::SCALE_W-1:0] scale_reg;
    logic wr_en;
    tbwpc_pkg::reg_index_t reg_sel;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign reg_sel = tbwpc_pkg::reg_index_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fpc_reg <= tbwpc_pkg::FPC_RESET;
            height_reg <= tbwpc_pkg::HEIGHT_RESET;
            cols_reg <= tbwpc_pkg::COLS_RESET;
            scale_reg <= tbwpc_pkg::SCALE_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                tbwpc_pkg::REG_FRAMES_PER_COLUMN: begin
                    fpc_reg <= pwdata[4:0];
                end
                tbwpc_pkg::REG_DISPLAY_HEIGHT: begin
                    height_reg <= pwdata[11:0];
                    // The multiply by the reciprocal is done once here, not per item.
                    scale_reg <= tbwpc_pkg::SCALE_W'(pwdata[11:0])
                                 * tbwpc_pkg::SCALE_W'(tbwpc_pkg::RECIP_510);
                end
                tbwpc_pkg::REG_COLUMN_COUNT: begin
                    cols_reg <= pwdata[12:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            tbwpc_pkg::REG_FRAMES_PER_COLUMN: prdata = 32'(fpc_reg);
            tbwpc_pkg::REG_DISPLAY_HEIGHT: prdata = 32'(height_reg);
            tbwpc_pkg::REG_COLUMN_COUNT: prdata = 32'(cols_reg);
            default: prdata = 32'd0;
        endcase
    end

    assign cfg.frames_per_column = fpc_reg;
    assign cfg.column_count = cols_reg;
    assign cfg.height_scale = scale_reg;

endmodule

// File: rtl/core/tbwpc_accum.sv
// Running band maxima, frame and column counters, and the finished column register.
module tbwpc_accum #(
    parameter int MAX_COLUMNS = 4096,
    parameter int MAX_FRAMES_PER_COLUMN = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  tbwpc_pkg::cfg_t cfg,
    input  logic s_valid,
    output logic s_ready,
    input  tbwpc_pkg::in_item_t s_payload,
    output logic col_valid,
    input  logic col_ready,
    output tbwpc_pkg::col_t col
);

    localparam int FW = (MAX_FRAMES_PER_COLUMN > 1) ? $clog2(MAX_FRAMES_PER_COLUMN) : 1;
    localparam int CW = $clog2(MAX_COLUMNS);

    logic [FW-1:0] frame_cnt_reg;
    logic [CW-1:0] col_cnt_reg;
    logic [tbwpc_pkg::NUM_MAGS-1:0][7:0] peaks_reg;
    logic [tbwpc_pkg::NUM_MAGS-1:0][7:0] peaks_next;
    logic [tbwpc_pkg::NUM_MAGS-1:0][7:0] in_mag;
    logic valid_reg;
    logic valid_next;
    tbwpc_pkg::col_t col_reg;
    logic col_valid_reg;

    logic [31:0] fpc_eff;
    logic [31:0] cols_eff;
    logic first_frame;
    logic col_end;
    logic last;
    logic accept;

    assign in_mag[0] = s_payload.low_left;
    assign in_mag[1] = s_payload.low_right;
    assign in_mag[2] = s_payload.mid_left;
    assign in_mag[3] = s_payload.mid_right;
    assign in_mag[4] = s_payload.high_left;
    assign in_mag[5] = s_payload.high_right;

    // Zero acts as one; values past the build limits saturate.
    always_comb begin
        if (cfg.frames_per_column == 5'd0) begin
            fpc_eff = 32'd1;
        end else if (32'(cfg.frames_per_column) > 32'(MAX_FRAMES_PER_COLUMN)) begin
            fpc_eff = 32'(MAX_FRAMES_PER_COLUMN);
        end else begin
            fpc_eff = 32'(cfg.frames_per_column);
        end
        if (cfg.column_count == 13'd0) begin
            cols_eff = 32'd1;
        end else if (32'(cfg.column_count) > 32'(MAX_COLUMNS)) begin
            cols_eff = 32'(MAX_COLUMNS);
        end else begin
            cols_eff = 32'(cfg.column_count);
        end
    end

    assign first_frame = (frame_cnt_reg == '0);
    assign col_end = (32'(frame_cnt_reg) + 32'd1 >= fpc_eff);
    assign last = (32'(col_cnt_reg) + 32'd1 >= cols_eff);
    assign s_ready = !col_valid_reg || col_ready;
    assign accept = s_valid && s_ready;

    always_comb begin
        for (int k = 0; k < tbwpc_pkg::NUM_MAGS; k++) begin
            if (first_frame || (in_mag[k] > peaks_reg[k])) begin
                peaks_next[k] = in_mag[k];
            end else begin
                peaks_next[k] = peaks_reg[k];
            end
        end
        // Only the first frame of a column decides whether it is drawn.
        valid_next = first_frame ? s_payload.in_range : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_cnt_reg <= '0;
            col_cnt_reg <= '0;
            peaks_reg <= '0;
            valid_reg <= 1'b0;
            col_valid_reg <= 1'b0;
        end else begin
            if (col_valid_reg && col_ready) begin
                col_valid_reg <= 1'b0;
            end
            if (accept) begin
                peaks_reg <= peaks_next;
                valid_reg <= valid_next;
                if (col_end) begin
                    frame_cnt_reg <= '0;
                    col_cnt_reg <= last ? '0 : col_cnt_reg + 1'b1;
                    col_valid_reg <= 1'b1;
                    col_reg.column_index <= 12'(col_cnt_reg);
                    col_reg.peaks <= peaks_next;
                    col_reg.column_valid <= valid_next;
                    col_reg.last_column <= last;
                end else begin
                    frame_cnt_reg <= frame_cnt_reg + 1'b1;
                end
            end
        end
    end

    assign col_valid = col_valid_reg;
    assign col = col_reg;

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (frame_cnt_reg == '0) && (col_cnt_reg == '0) && !col_valid_reg)
        else $error("accumulator state not cleared by reset");

    a_column_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && col_end |=> col_valid_reg && (col_reg.last_column == $past(last)))
        else $error("finished column not queued for scaling");

    a_sweep_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && col_end && last |=> (col_cnt_reg == '0) && (frame_cnt_reg == '0))
        else $error("sweep did not wrap to column zero");

    a_frame_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(frame_cnt_reg) < 32'(MAX_FRAMES_PER_COLUMN))
        else $error("frame counter ran past the column length");

endmodule

// File: rtl/core/tbwpc_scale.sv
// Converts a finished column's peaks into y coordinates and holds the result item.
module tbwpc_scale (
    input  logic aclk,
    input  logic aresetn,
    input  tbwpc_pkg::cfg_t cfg,
    input  logic col_valid,
    output logic col_ready,
    input  tbwpc_pkg::col_t col,
    output logic m_valid,
    input  logic m_ready,
    output tbwpc_pkg::out_item_t m_payload
);

    logic m_valid_reg;
    tbwpc_pkg::out_item_t m_payload_reg;
    tbwpc_pkg::out_item_t m_payload_next;
    logic [tbwpc_pkg::NUM_BANDS-1:0][11:0] top;
    logic [tbwpc_pkg::NUM_BANDS-1:0][11:0] bottom;

    assign col_ready = !m_valid_reg || m_ready;

    always_comb begin
        for (int b = 0; b < tbwpc_pkg::NUM_BANDS; b++) begin
            if (col.column_valid) begin
                top[b] = tbwpc_pkg::y_coord(tbwpc_pkg::MAG_MID - 9'(col.peaks[2*b]),
                                            cfg.height_scale);
                bottom[b] = tbwpc_pkg::y_coord(tbwpc_pkg::MAG_MID + 9'(col.peaks[2*b+1]),
                                               cfg.height_scale);
            end else begin
                top[b] = 12'd0;
                bottom[b] = 12'd0;
            end
        end
        m_payload_next.column_index = col.column_index;
        m_payload_next.low_top = top[0];
        m_payload_next.low_bottom = bottom[0];
        m_payload_next.mid_top = top[1];
        m_payload_next.mid_bottom = bottom[1];
        m_payload_next.high_top = top[2];
        m_payload_next.high_bottom = bottom[2];
        m_payload_next.last_column = col.last_column;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (col_ready) begin
            m_valid_reg <= col_valid;
            if (col_valid) begin
                m_payload_reg <= m_payload_next;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

// File: rtl/core/three_band_waveform_peak_columns_top.sv
// Top level of the three-band waveform peak column block.
// A closing item fills the column register; its result then fills the output register.
// Throughput: one item per cycle while s_ready is high; the column register and the output
// register each take a new entry whenever the stage after them moves on.
// Reset (aresetn low, synchronous) clears counters, maxima and both valid flags and
// restores the registers to 1 frame per column, height 256 and 1024 columns.
module three_band_waveform_peak_columns_top #(
    parameter int MAX_COLUMNS = 4096,
    parameter int MAX_FRAMES_PER_COLUMN = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [3:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready,
    input  logic s_valid,
    output logic s_ready,
    input  tbwpc_pkg::in_item_t s_payload,
    output logic m_valid,
    input  logic m_ready,
    output tbwpc_pkg::out_item_t m_payload
);

    tbwpc_pkg::cfg_t cfg;
    tbwpc_pkg::col_t col;
    logic col_valid;
    logic col_ready;

    tbwpc_regs u_regs (
        .aclk(aclk),
        .aresetn(aresetn),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .cfg(cfg)
    );

    tbwpc_accum #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_FRAMES_PER_COLUMN(MAX_FRAMES_PER_COLUMN)
    ) u_accum (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg(cfg),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_payload(s_payload),
        .col_valid(col_valid),
        .col_ready(col_ready),
        .col(col)
    );

    tbwpc_scale u_scale (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg(cfg),
        .col_valid(col_valid),
        .col_ready(col_ready),
        .col(col),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_payload(m_payload)
    );

endmodule

// File: verif/three_band_waveform_peak_columns_top_tb.sv
// Self-checking testbench for the three-band waveform peak column block.
module three_band_waveform_peak_columns_top_tb;

    localparam int ITEM_TARGET = 1950;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_PAUSE = 4;
    localparam int FPC_LIMIT = 16;
    localparam int COLS_LIMIT = 4096;
    localparam logic [3:0] UNMAPPED_ADDR = 4'hC;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_CHOPPY
    } rx_mode_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    tbwpc_pkg::in_item_t s_payload = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    tbwpc_pkg::out_item_t m_payload;

    three_band_waveform_peak_columns_top u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_payload(s_payload),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_payload(m_payload)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Register shadow and column state of the predictor.
    logic [4:0] cfg_fpc = tbwpc_pkg::FPC_RESET;
    logic [11:0] cfg_height = tbwpc_pkg::HEIGHT_RESET;
    logic [12:0] cfg_cols = tbwpc_pkg::COLS_RESET;
    logic [7:0] peaks [tbwpc_pkg::NUM_MAGS];
    int unsigned frames_in_column = 0;
    int unsigned column_at = 0;
    logic column_live = 1'b0;

    tbwpc_pkg::in_item_t frames_to_send[$];
    tbwpc_pkg::out_item_t pending_columns[$];
    int unsigned frames_issued = 0;
    int unsigned frames_taken = 0;
    int unsigned err_count = 0;
    int unsigned quiet_cycles = 0;

    logic frame_took = 1'b0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    rx_mode_t rx_mode = RX_OPEN;
    int unsigned rx_span = 0;

    function automatic logic [11:0] band_y(logic [11:0] height, int unsigned span);
        longint unsigned scaled;
        scaled = (longint'(height) * span) / 510;
        return scaled[11:0];
    endfunction

    // Folds one accepted frame into the column and queues the column it closes, if any.
    function automatic void fold_frame(tbwpc_pkg::in_item_t f);
        logic [7:0] mags [tbwpc_pkg::NUM_MAGS];
        int unsigned fpc_eff;
        int unsigned cols_eff;
        logic closes;
        tbwpc_pkg::out_item_t col;
        mags[0] = f.low_left;
        mags[1] = f.low_right;
        mags[2] = f.mid_left;
        mags[3] = f.mid_right;
        mags[4] = f.high_left;
        mags[5] = f.high_right;
        fpc_eff = (cfg_fpc == 0) ? 1 : ((cfg_fpc > FPC_LIMIT) ? FPC_LIMIT : cfg_fpc);
        cols_eff = (cfg_cols == 0) ? 1 : ((cfg_cols > COLS_LIMIT) ? COLS_LIMIT : cfg_cols);
        if (frames_in_column == 0) begin
            for (int k = 0; k < tbwpc_pkg::NUM_MAGS; k++) peaks[k] = mags[k];
            column_live = f.in_range;
        end else begin
            for (int k = 0; k < tbwpc_pkg::NUM_MAGS; k++) begin
                if (mags[k] > peaks[k]) peaks[k] = mags[k];
            end
        end
        frames_in_column++;
        if (frames_in_column < fpc_eff) return;
        frames_in_column = 0;
        closes = (column_at + 1 >= cols_eff);
        col = '0;
        col.column_index = column_at[11:0];
        if (column_live) begin
            col.low_top = band_y(cfg_height, 255 - peaks[0]);
            col.low_bottom = band_y(cfg_height, 255 + peaks[1]);
            col.mid_top = band_y(cfg_height, 255 - peaks[2]);
            col.mid_bottom = band_y(cfg_height, 255 + peaks[3]);
            col.high_top = band_y(cfg_height, 255 - peaks[4]);
            col.high_bottom = band_y(cfg_height, 255 + peaks[5]);
        end
        col.last_column = closes;
        column_at = closes ? 0 : column_at + 1;
        pending_columns.insert(pending_columns.size(), col);
    endfunction

    function automatic void match_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    function automatic void check_column(tbwpc_pkg::out_item_t got);
        tbwpc_pkg::out_item_t want;
        if (pending_columns.size() == 0) begin
            $error("column %0d arrived with none expected", got.column_index);
            err_count++;
            return;
        end
        want = pending_columns.pop_front();
        match_field("column_index", want.column_index, got.column_index);
        match_field("low_top", want.low_top, got.low_top);
        match_field("low_bottom", want.low_bottom, got.low_bottom);
        match_field("mid_top", want.mid_top, got.mid_top);
        match_field("mid_bottom", want.mid_bottom, got.mid_bottom);
        match_field("high_top", want.high_top, got.high_top);
        match_field("high_bottom", want.high_bottom, got.high_bottom);
        match_field("last_column", want.last_column, got.last_column);
    endfunction

    // Monitor, predictor hook and watchdog.
    always @(posedge aclk) begin
        frame_took <= s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) check_column(m_payload);
            if (s_valid && s_ready) begin
                fold_frame(s_payload);
                frames_taken++;
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) ||
                (frames_taken == frames_issued && pending_columns.size() == 0)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Sender: bursts of items separated by random gaps, now and then a long unbroken run.
    always @(negedge aclk) begin
        if (!s_valid || frame_took) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (frames_to_send.size() != 0) begin
                s_payload <= frames_to_send.pop_front();
                s_valid <= 1'b1;
                if (burst_left <= 1) begin
                    if ($urandom_range(0, 7) == 0) begin
                        burst_left <= $urandom_range(40, 120);
                        gap_left <= 0;
                    end else begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= $urandom_range(0, 6);
                    end
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: switches at random between stall patterns: always ready, coin flip, sparse and choppy.
    always @(negedge aclk) begin
        if (rx_span == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_span <= $urandom_range(20, 200);
            m_ready <= 1'b1;
        end else begin
            rx_span <= rx_span - 1;
            case (rx_mode)
                RX_OPEN:    m_ready <= 1'b1;
                RX_COIN:    m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE:  m_ready <= (rx_span % 4 == 0);
                default:    m_ready <= (rx_span % 7 < 4);
            endcase
        end
    end

    task automatic reg_read(input logic [3:0] addr);
        logic [31:0] want;
        case (addr[3:2])
            tbwpc_pkg::REG_FRAMES_PER_COLUMN: want = {27'd0, cfg_fpc};
            tbwpc_pkg::REG_DISPLAY_HEIGHT:    want = {20'd0, cfg_height};
            default:                          want = {19'd0, cfg_cols};
        endcase
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== want) begin
            $error("prdata at 0x%0h: expected 0x%0h, got 0x%0h", addr, want, prdata);
            err_count++;
        end
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes a register, updates the shadow at the write edge and reads back all but UNMAPPED_ADDR.
    task automatic reg_write(input logic [3:0] addr, input logic [31:0] word);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= word;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (addr[1:0] == 2'b00) begin
            case (addr[3:2])
                tbwpc_pkg::REG_FRAMES_PER_COLUMN: cfg_fpc = word[4:0];
                tbwpc_pkg::REG_DISPLAY_HEIGHT:    cfg_height = word[11:0];
                tbwpc_pkg::REG_COLUMN_COUNT:      cfg_cols = word[12:0];
                default: ;
            endcase
        end
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr != UNMAPPED_ADDR) reg_read(addr);
    endtask

    // Waits until every frame is taken and every column has come out, then lets the
    // pipeline settle so that no register changes under a frame still in flight.
    task automatic drain();
        while (frames_taken != frames_issued || pending_columns.size() != 0) @(negedge aclk);
        repeat (DRAIN_PAUSE) @(negedge aclk);
    endtask

    function automatic void queue_frame(tbwpc_pkg::in_item_t f);
        frames_to_send.insert(frames_to_send.size(), f);
        frames_issued++;
    endfunction

    function automatic tbwpc_pkg::in_item_t uniform_frame(logic [7:0] m, logic live);
        return {m, m, m, m, m, m, live};
    endfunction

    function automatic tbwpc_pkg::in_item_t random_frame();
        logic [7:0] m [tbwpc_pkg::NUM_MAGS];
        for (int k = 0; k < tbwpc_pkg::NUM_MAGS; k++) begin
            case ($urandom_range(0, 9))
                0:       m[k] = 8'd0;
                1:       m[k] = 8'd255;
                2, 3:    m[k] = 8'($urandom_range(240, 255));
                4:       m[k] = 8'($urandom_range(0, 15));
                default: m[k] = 8'($urandom_range(0, 255));
            endcase
        end
        return {m[0], m[1], m[2], m[3], m[4], m[5], ($urandom_range(0, 7) != 0)};
    endfunction

    localparam logic [3:0] FPC_ADDR = {tbwpc_pkg::REG_FRAMES_PER_COLUMN, 2'b00};
    localparam logic [3:0] HEIGHT_ADDR = {tbwpc_pkg::REG_DISPLAY_HEIGHT, 2'b00};
    localparam logic [3:0] COLS_ADDR = {tbwpc_pkg::REG_COLUMN_COUNT, 2'b00};

    initial begin
        logic [31:0] word;
        int unsigned batch;
        bit first_phase;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset values, then extremes at the default settings.
        reg_read(FPC_ADDR);
        reg_read(HEIGHT_ADDR);
        reg_read(COLS_ADDR);
        queue_frame(uniform_frame(8'd0, 1'b1));
        queue_frame(uniform_frame(8'd255, 1'b1));
        drain();

        // Tallest display and a three-column sweep, so the sweep wraps right away.
        reg_write(HEIGHT_ADDR, 32'd4095);
        reg_write(COLS_ADDR, 32'd3);
        queue_frame({8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 1'b1});
        queue_frame({8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 1'b1});
        queue_frame(uniform_frame(8'd255, 1'b0));
        queue_frame({8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 1'b1});
        drain();

        // Only the first frame of a column decides whether the column is shown.
        reg_write(FPC_ADDR, 32'd3);
        queue_frame(uniform_frame(8'd3, 1'b0));
        queue_frame(uniform_frame(8'd200, 1'b1));
        queue_frame(uniform_frame(8'd90, 1'b1));
        queue_frame(uniform_frame(8'd7, 1'b1));
        queue_frame(uniform_frame(8'd250, 1'b0));
        queue_frame({8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 1'b0});
        drain();

        // Zero frames per column, zero height and zero columns.
        reg_write(FPC_ADDR, 32'd0);
        reg_write(HEIGHT_ADDR, 32'd0);
        reg_write(COLS_ADDR, 32'd0);
        queue_frame(uniform_frame(8'd255, 1'b1));
        queue_frame({8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 1'b1});
        drain();

        // Shorten the column while it is half full; a write to an unmapped address is ignored.
        reg_write(FPC_ADDR, 32'd4);
        reg_write(HEIGHT_ADDR, 32'd100);
        reg_write(COLS_ADDR, 32'd4096);
        queue_frame(uniform_frame(8'd40, 1'b1));
        queue_frame(uniform_frame(8'd80, 1'b1));
        drain();
        reg_write(UNMAPPED_ADDR, 32'hFFFF_FFFF);
        reg_write(FPC_ADDR, 32'd2);
        queue_frame(uniform_frame(8'd20, 1'b0));
        drain();

        first_phase = 1'b1;
        while (frames_issued < ITEM_TARGET) begin
            if (first_phase || $urandom_range(0, 2) != 0) begin
                word = $urandom();
                case ($urandom_range(0, 9))
                    0:          word[4:0] = 5'd0;
                    1:          word[4:0] = 5'd16;
                    2:          word[4:0] = 5'($urandom_range(17, 31));
                    3, 4, 5:    word[4:0] = 5'd1;
                    6, 7:       word[4:0] = 5'($urandom_range(2, 4));
                    default:    word[4:0] = 5'($urandom_range(5, 15));
                endcase
                reg_write(FPC_ADDR, word);
            end
            if (first_phase || $urandom_range(0, 2) != 0) begin
                word = $urandom();
                case ($urandom_range(0, 7))
                    0:       word[11:0] = 12'd0;
                    1:       word[11:0] = 12'd1;
                    2:       word[11:0] = 12'd4095;
                    3:       word[11:0] = 12'd256;
                    default: word[11:0] = 12'($urandom_range(0, 4095));
                endcase
                reg_write(HEIGHT_ADDR, word);
            end
            if (first_phase || $urandom_range(0, 2) != 0) begin
                word = $urandom();
                case ($urandom_range(0, 9))
                    0:       word[12:0] = 13'd0;
                    1:       word[12:0] = 13'd1;
                    2:       word[12:0] = 13'd4096;
                    3:       word[12:0] = 13'd8191;
                    4:       word[12:0] = 13'($urandom_range(4097, 8190));
                    5, 6:    word[12:0] = 13'($urandom_range(2, 8));
                    default: word[12:0] = 13'($urandom_range(9, 4095));
                endcase
                reg_write(COLS_ADDR, word);
            end
            first_phase = 1'b0;
            batch = $urandom_range(80, 220);
            repeat (batch) queue_frame(random_frame());
            drain();
        end

        repeat (DRAIN_PAUSE) @(negedge aclk);
        if (pending_columns.size() != 0) begin
            $error("%0d expected columns never arrived", pending_columns.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
